/* sv/assert_macros.svh */
// Concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DQVL_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("dqvl assertion failed");
`define DQVL_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dqvl implication failed");
`else
`define DQVL_ASSERT(label, clk, rst_n, prop)
`define DQVL_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/dqvl_pkg.sv */
package dqvl_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VOLTAGE_LIMIT = 2'd0,
		REG_FLUX_PRIORITY = 2'd1
	} cfg_reg_t;

	localparam logic [14:0] LIMIT_RESET = 15'd32767;
	localparam logic [14:0] Q15_MAX_U   = 15'd32767;
	localparam logic signed [15:0] Q15_MAX = 16'sd32767;
	localparam logic signed [15:0] Q15_MIN = -16'sd32768;

	localparam int SQ_W   = 32;
	localparam int REM_W  = 30;
	localparam int ROOT_W = SQ_W / 2;
	localparam int M_W    = REM_W / 2;
	localparam int QUO_W  = 15;
	localparam int DIV_W  = 16;

	typedef struct packed {
		logic signed [31:0] d_raw;
		logic signed [31:0] q_raw;
		logic signed [15:0] ds;
		logic signed [15:0] qs;
		logic signed [15:0] p;
		logic [14:0]        lim;
		logic               prio;
		logic [14:0]        rem;
		logic [ROOT_W-1:0]  root;
		logic [M_W-1:0]     m;
	} side_t;

	localparam int SIDE_W = $bits(side_t);

	function automatic logic signed [15:0] clamp16(input logic signed [31:0] x);
		if (x > 32'(Q15_MAX))
			return Q15_MAX;
		else if (x < 32'(Q15_MIN))
			return Q15_MIN;
		else
			return x[15:0];
	endfunction

	function automatic logic signed [15:0] clamp_sym(input logic signed [15:0] x,
		input logic [14:0] b);
		logic signed [15:0] bs;
		bs = $signed({1'b0, b});
		if (x > bs)
			return bs;
		else if (x < -bs)
			return -bs;
		else
			return x;
	endfunction

	function automatic logic signed [31:0] sat_diff(input logic signed [15:0] o,
		input logic signed [31:0] r);
		logic signed [32:0] d;
		d = {{17{o[15]}}, o} - {r[31], r};
		if (d[32] != d[31])
			return d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		else
			return d[31:0];
	endfunction

endpackage

/* sv/dqvl_ifs.sv */
interface dqvl_cmd_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] d_command;
	logic signed [31:0] q_command;
	modport source(output valid, d_command, q_command, input ready);
	modport sink(input valid, d_command, q_command, output ready);
endinterface

interface dqvl_res_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] d_out;
	logic signed [15:0] q_out;
	logic signed [31:0] d_residual;
	logic signed [31:0] q_residual;
	logic               limited;
	logic [14:0]        limit_ratio;
	modport source(output valid, d_out, q_out, d_residual, q_residual, limited,
		limit_ratio, input ready);
	modport sink(input valid, d_out, q_out, d_residual, q_residual, limited,
		limit_ratio, output ready);
endinterface

interface dqvl_cfg_if;
	import dqvl_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* sv/dqvl_front.sv */
module dqvl_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       in_valid,
	input  logic signed [31:0]         d_command,
	input  logic signed [31:0]         q_command,
	input  logic [14:0]                lim,
	input  logic                       prio,
	output logic                       out_valid,
	output logic [dqvl_pkg::SQ_W-1:0]  out_sq,
	output dqvl_pkg::side_t            out_side
);
	import dqvl_pkg::*;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic signed [31:0] d_raw_s1, q_raw_s1, d_raw_s2, q_raw_s2, d_raw_s3, q_raw_s3;
	logic signed [15:0] ds_s1, qs_s1, ds_s2, qs_s2, ds_s3, qs_s3;
	logic [14:0]        lim_s1, lim_s2, lim_s3;
	logic               prio_s1, prio_s2, prio_s3;
	logic signed [15:0] p_s2, p_s3;
	logic [30:0]        dsq_s2, qsq_s2;
	logic [29:0]        lim2_s2;
	logic [SQ_W-1:0]    sq_s3;
	logic [14:0]        p2_s3, l2_s3;
	logic signed [31:0] dsq_w, qsq_w, psq_w;
	logic [29:0]        lim2_w;
	side_t              side_s4;
	logic [SQ_W-1:0]    sq_s4;

	assign dsq_w  = ds_s1 * ds_s1;
	assign qsq_w  = qs_s1 * qs_s1;
	assign lim2_w = lim_s1 * lim_s1;
	assign psq_w  = p_s2 * p_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_raw_s1 <= d_command;
			q_raw_s1 <= q_command;
			ds_s1    <= clamp16(d_command);
			qs_s1    <= clamp16(q_command);
			lim_s1   <= lim;
			prio_s1  <= prio;

			d_raw_s2 <= d_raw_s1;
			q_raw_s2 <= q_raw_s1;
			ds_s2    <= ds_s1;
			qs_s2    <= qs_s1;
			lim_s2   <= lim_s1;
			prio_s2  <= prio_s1;
			dsq_s2   <= dsq_w[30:0];
			qsq_s2   <= qsq_w[30:0];
			lim2_s2  <= lim2_w;
			p_s2     <= clamp_sym(prio_s1 ? ds_s1 : qs_s1, lim_s1);

			d_raw_s3 <= d_raw_s2;
			q_raw_s3 <= q_raw_s2;
			ds_s3    <= ds_s2;
			qs_s3    <= qs_s2;
			lim_s3   <= lim_s2;
			prio_s3  <= prio_s2;
			p_s3     <= p_s2;
			sq_s3    <= {1'b0, dsq_s2} + {1'b0, qsq_s2};
			p2_s3    <= psq_w[29:15];
			l2_s3    <= lim2_s2[29:15];

			sq_s4         <= sq_s3;
			side_s4.d_raw <= d_raw_s3;
			side_s4.q_raw <= q_raw_s3;
			side_s4.ds    <= ds_s3;
			side_s4.qs    <= qs_s3;
			side_s4.p     <= p_s3;
			side_s4.lim   <= lim_s3;
			side_s4.prio  <= prio_s3;
			side_s4.rem   <= (l2_s3 >= p2_s3) ? (l2_s3 - p2_s3) : 15'd0;
			side_s4.root  <= '0;
			side_s4.m     <= '0;
		end
	end

	assign out_valid = v_s4;
	assign out_sq    = sq_s4;
	assign out_side  = side_s4;
endmodule

/* sv/dqvl_isqrt.sv */
module dqvl_isqrt #(
	parameter int N  = 32,
	parameter int SW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_valid,
	input  logic [N-1:0]   in_rad,
	input  logic [SW-1:0]  in_side,
	output logic           out_valid,
	output logic [N/2-1:0] out_root,
	output logic [SW-1:0]  out_side
);
	localparam int R = N / 2;

	logic          v_s    [R];
	logic [N-1:0]  rad_s  [R];
	logic [R:0]    rem_s  [R];
	logic [R-1:0]  root_s [R];
	logic [SW-1:0] side_s [R];

	for (genvar k = 0; k < R; k++) begin : g_stage
		logic          pv;
		logic [N-1:0]  prad;
		logic [R:0]    prem;
		logic [R-1:0]  proot;
		logic [SW-1:0] pside;
		logic [R+2:0]  rem_n, trial, diff;

		if (k == 0) begin : g_first
			assign pv    = in_valid;
			assign prad  = in_rad;
			assign prem  = '0;
			assign proot = '0;
			assign pside = in_side;
		end else begin : g_next
			assign pv    = v_s[k-1];
			assign prad  = rad_s[k-1];
			assign prem  = rem_s[k-1];
			assign proot = root_s[k-1];
			assign pside = side_s[k-1];
		end

		assign rem_n = {prem, prad[N-1 -: 2]};
		assign trial = {1'b0, proot, 2'b01};
		assign diff  = rem_n - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k] <= 1'b0;
			else if (adv)
				v_s[k] <= pv;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rad_s[k]  <= prad << 2;
				side_s[k] <= pside;
				if (rem_n >= trial) begin
					rem_s[k]  <= diff[R:0];
					root_s[k] <= {proot[R-2:0], 1'b1};
				end else begin
					rem_s[k]  <= rem_n[R:0];
					root_s[k] <= {proot[R-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_s[R-1];
	assign out_root  = root_s[R-1];
	assign out_side  = side_s[R-1];
endmodule

/* sv/dqvl_div.sv */
module dqvl_div #(
	parameter int QW = 15,
	parameter int DW = 16,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          in_valid,
	input  logic [QW-1:0] in_num,
	input  logic [DW-1:0] in_div,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [QW-1:0] out_quo,
	output logic [SW-1:0] out_side
);
	logic          v_s    [QW];
	logic [DW-1:0] r_s    [QW];
	logic [DW-1:0] dv_s   [QW];
	logic [QW-1:0] q_s    [QW];
	logic [SW-1:0] side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic          pv;
		logic [DW-1:0] pr, pdv;
		logic [QW-1:0] pq;
		logic [SW-1:0] pside;
		logic [DW:0]   r_n, dx, diff;

		if (k == 0) begin : g_first
			assign pv    = in_valid;
			assign pr    = {{(DW-QW){1'b0}}, in_num};
			assign pdv   = in_div;
			assign pq    = '0;
			assign pside = in_side;
		end else begin : g_next
			assign pv    = v_s[k-1];
			assign pr    = r_s[k-1];
			assign pdv   = dv_s[k-1];
			assign pq    = q_s[k-1];
			assign pside = side_s[k-1];
		end

		assign r_n  = {pr, 1'b0};
		assign dx   = {1'b0, pdv};
		assign diff = r_n - dx;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k] <= 1'b0;
			else if (adv)
				v_s[k] <= pv;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[k]   <= pdv;
				side_s[k] <= pside;
				if (r_n >= dx) begin
					r_s[k] <= diff[DW-1:0];
					q_s[k] <= {pq[QW-2:0], 1'b1};
				end else begin
					r_s[k] <= r_n[DW-1:0];
					q_s[k] <= {pq[QW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign out_quo   = q_s[QW-1];
	assign out_side  = side_s[QW-1];
endmodule

/* sv/dqvl_back.sv */
module dqvl_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  dqvl_pkg::side_t    in_side,
	input  logic [14:0]        in_ratio,
	output logic               out_valid,
	output logic signed [15:0] d_out,
	output logic signed [15:0] q_out,
	output logic signed [31:0] d_residual,
	output logic signed [31:0] q_residual,
	output logic               limited,
	output logic [14:0]        limit_ratio
);
	import dqvl_pkg::*;

	logic               v_s1, v_s2;
	logic signed [15:0] d_s1, q_s1, d_s2, q_s2;
	logic signed [31:0] d_raw_s1, q_raw_s1, dr_s2, qr_s2;
	logic               lmt_s1, lmt_s2;
	logic [14:0]        ratio_s1, ratio_s2;
	logic [14:0]        mag;
	logic signed [15:0] d_w, q_w;
	logic               lmt_w;
	logic [14:0]        ratio_w;

	assign mag = (in_side.root > {1'b0, Q15_MAX_U}) ? Q15_MAX_U : in_side.root[14:0];

	always_comb begin
		d_w     = in_side.ds;
		q_w     = in_side.qs;
		lmt_w   = (32'(in_side.ds) != in_side.d_raw) || (32'(in_side.qs) != in_side.q_raw);
		ratio_w = Q15_MAX_U;
		if (in_side.lim == '0) begin
			d_w     = '0;
			q_w     = '0;
			lmt_w   = 1'b1;
			ratio_w = '0;
		end else if (mag > in_side.lim) begin
			lmt_w   = 1'b1;
			ratio_w = in_ratio;
			if (in_side.prio) begin
				d_w = in_side.p;
				q_w = clamp_sym(in_side.qs, in_side.m);
			end else begin
				q_w = in_side.p;
				d_w = clamp_sym(in_side.ds, in_side.m);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1     <= d_w;
			q_s1     <= q_w;
			d_raw_s1 <= in_side.d_raw;
			q_raw_s1 <= in_side.q_raw;
			lmt_s1   <= lmt_w;
			ratio_s1 <= ratio_w;

			d_s2     <= d_s1;
			q_s2     <= q_s1;
			dr_s2    <= sat_diff(d_s1, d_raw_s1);
			qr_s2    <= sat_diff(q_s1, q_raw_s1);
			lmt_s2   <= lmt_s1;
			ratio_s2 <= ratio_s1;
		end
	end

	assign out_valid   = v_s2;
	assign d_out       = d_s2;
	assign q_out       = q_s2;
	assign d_residual  = dr_s2;
	assign q_residual  = qr_s2;
	assign limited     = lmt_s2;
	assign limit_ratio = ratio_s2;
endmodule

/* sv/dq_voltage_vector_limiter_unit.sv */
// Pipeline: 4 front, 16 magnitude root, 15 remainder root, 15 ratio divide and 2 output
// stages from request acceptance to result valid.
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// Reset: asynchronous, active low; clears all valid bits, voltage_limit to 32767
// and flux_priority to 0.
`include "assert_macros.svh"
module dq_voltage_vector_limiter_unit (
	input  logic clk,
	input  logic arst_n,
	dqvl_cmd_if.sink   cmd,
	dqvl_res_if.source res,
	dqvl_cfg_if.sink   cfg
);
	import dqvl_pkg::*;

	logic            adv;
	logic [14:0]     voltage_limit_q;
	logic            flux_priority_q;

	logic            f_valid;
	logic [SQ_W-1:0] f_sq;
	side_t           f_side;

	logic              r1_valid;
	logic [ROOT_W-1:0] r1_root;
	logic [SIDE_W-1:0] r1_side_v;
	side_t             r1_side, r2_in_side;

	logic              r2_valid;
	logic [M_W-1:0]    r2_m;
	logic [SIDE_W-1:0] r2_side_v;
	side_t             r2_side, dv_in_side;
	logic [DIV_W-1:0]  mag;

	logic              dv_valid;
	logic [QUO_W-1:0]  dv_quo;
	logic [SIDE_W-1:0] dv_side_v;

	assign adv       = !res.valid || res.ready;
	assign cmd.ready = adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voltage_limit_q <= LIMIT_RESET;
			flux_priority_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_VOLTAGE_LIMIT: voltage_limit_q <= cfg.data[14:0];
				REG_FLUX_PRIORITY: flux_priority_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	dqvl_front u_front (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(cmd.valid), .d_command(cmd.d_command), .q_command(cmd.q_command),
		.lim(voltage_limit_q), .prio(flux_priority_q),
		.out_valid(f_valid), .out_sq(f_sq), .out_side(f_side)
	);

	dqvl_isqrt #(.N(SQ_W), .SW(SIDE_W)) u_mag_root (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(f_valid), .in_rad(f_sq), .in_side(f_side),
		.out_valid(r1_valid), .out_root(r1_root), .out_side(r1_side_v)
	);

	assign r1_side = r1_side_v;
	always_comb begin
		r2_in_side      = r1_side;
		r2_in_side.root = r1_root;
	end

	dqvl_isqrt #(.N(REM_W), .SW(SIDE_W)) u_rem_root (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(r1_valid), .in_rad({r1_side.rem, {(REM_W-15){1'b0}}}),
		.in_side(r2_in_side),
		.out_valid(r2_valid), .out_root(r2_m), .out_side(r2_side_v)
	);

	assign r2_side = r2_side_v;
	assign mag = (r2_side.root > {1'b0, Q15_MAX_U}) ? {1'b0, Q15_MAX_U} : r2_side.root;
	always_comb begin
		dv_in_side   = r2_side;
		dv_in_side.m = r2_m;
	end

	dqvl_div #(.QW(QUO_W), .DW(DIV_W), .SW(SIDE_W)) u_ratio_div (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(r2_valid), .in_num(r2_side.lim), .in_div(mag), .in_side(dv_in_side),
		.out_valid(dv_valid), .out_quo(dv_quo), .out_side(dv_side_v)
	);

	dqvl_back u_back (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(dv_valid), .in_side(dv_side_v), .in_ratio(dv_quo),
		.out_valid(res.valid), .d_out(res.d_out), .q_out(res.q_out),
		.d_residual(res.d_residual), .q_residual(res.q_residual),
		.limited(res.limited), .limit_ratio(res.limit_ratio)
	);

	`DQVL_IMPLIES(a_unlimited_ratio, clk, arst_n, res.valid && !res.limited, res.limit_ratio == Q15_MAX_U)
	`DQVL_IMPLIES(a_zero_ratio_zero_out, clk, arst_n, res.valid && res.limit_ratio == '0, res.d_out == '0 && res.q_out == '0 && res.limited)
	`DQVL_ASSERT(a_stall_blocks_cmd, clk, arst_n, (res.valid && !res.ready) |-> !cmd.ready)
endmodule

/* tb/sv/dq_voltage_vector_limiter_unit_tb.sv */
`timescale 1ns / 100ps
module dq_voltage_vector_limiter_unit_tb;
	import dqvl_pkg::*;

	typedef struct {
		logic signed [15:0] d_out;
		logic signed [15:0] q_out;
		logic signed [31:0] d_residual;
		logic signed [31:0] q_residual;
		logic               limited;
		logic [14:0]        limit_ratio;
	} limited_vec_t;

	localparam longint I32_MIN = -64'sd2147483648;
	localparam longint I32_MAX = 64'sd2147483647;

	logic clk;
	logic arst_n;
	dqvl_cmd_if cmd();
	dqvl_res_if res();
	dqvl_cfg_if cfg();

	dq_voltage_vector_limiter_unit dut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd.sink), .res(res.source), .cfg(cfg.sink)
	);

	limited_vec_t expected_vecs[$];
	logic [14:0] lim_setting;
	logic        prio_setting;
	int errors;
	int burst_left;
	logic stall_mode;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("FAIL");
		$finish;
	end

	function automatic longint floor_root(longint n);
		longint r;
		longint b;
		r = 0;
		b = longint'(1) << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint bound(longint x, longint lo, longint hi);
		if (x < lo)
			return lo;
		if (x > hi)
			return hi;
		return x;
	endfunction

	function automatic limited_vec_t limit_vector(logic signed [31:0] dc,
		logic signed [31:0] qc);
		limited_vec_t v;
		longint dr, qr, ds, qs, lim, dout, qout, mag, p, rem, m;
		dr = dc;
		qr = qc;
		ds = bound(dr, -32768, 32767);
		qs = bound(qr, -32768, 32767);
		lim = lim_setting;
		dout = 0;
		qout = 0;
		if (lim == 0) begin
			v.limited = 1'b1;
			v.limit_ratio = 15'd0;
		end else begin
			mag = floor_root(ds * ds + qs * qs);
			if (mag > 32767)
				mag = 32767;
			if (mag <= lim) begin
				dout = ds;
				qout = qs;
				v.limited = (ds != dr) || (qs != qr);
				v.limit_ratio = Q15_MAX_U;
			end else begin
				v.limited = 1'b1;
				v.limit_ratio = 15'((lim << 15) / mag);
				p = bound(prio_setting ? ds : qs, -lim, lim);
				rem = bound(((lim * lim) >> 15) - ((p * p) >> 15), 0, 32767);
				m = floor_root(rem << 15);
				if (prio_setting) begin
					dout = p;
					qout = bound(qs, -m, m);
				end else begin
					qout = p;
					dout = bound(ds, -m, m);
				end
			end
		end
		v.d_out = 16'(dout);
		v.q_out = 16'(qout);
		v.d_residual = 32'(bound(dout - dr, I32_MIN, I32_MAX));
		v.q_residual = 32'(bound(qout - qr, I32_MIN, I32_MAX));
		return v;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		limited_vec_t w;
		if (arst_n && res.valid && res.ready) begin
			if (expected_vecs.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				w = expected_vecs.pop_front();
				if (res.d_out !== w.d_out)
					report_mismatch("d_out", res.d_out, w.d_out);
				if (res.q_out !== w.q_out)
					report_mismatch("q_out", res.q_out, w.q_out);
				if (res.d_residual !== w.d_residual)
					report_mismatch("d_residual", res.d_residual, w.d_residual);
				if (res.q_residual !== w.q_residual)
					report_mismatch("q_residual", res.q_residual, w.q_residual);
				if (res.limited !== w.limited)
					report_mismatch("limited", res.limited, w.limited);
				if (res.limit_ratio !== w.limit_ratio)
					report_mismatch("limit_ratio", res.limit_ratio, w.limit_ratio);
			end
		end
	end

	// stall the result side on its own pattern
	always @(posedge clk) begin
		if (($urandom & 63) == 0)
			stall_mode <= ~stall_mode;
		if (stall_mode)
			res.ready <= ($urandom_range(0, 3) != 0);
		else
			res.ready <= 1'b1;
	end

	task automatic send_request(logic signed [31:0] d, logic signed [31:0] q);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				cmd.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		cmd.valid <= 1'b1;
		cmd.d_command <= d;
		cmd.q_command <= q;
		do
			@(posedge clk);
		while (!cmd.ready);
		expected_vecs.push_back(limit_vector(d, q));
		burst_left--;
	endtask

	task automatic drain_results();
		cmd.valid <= 1'b0;
		while (expected_vecs.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_register(cfg_reg_t idx, logic [15:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(posedge clk);
		if (idx == REG_VOLTAGE_LIMIT)
			lim_setting = value[14:0];
		else
			prio_setting = value[0];
	endtask

	function automatic logic signed [31:0] pick_command();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $signed(32'($urandom_range(0, 65535))) - 32768;
			2: return $signed(32'($urandom_range(0, 80000))) - 40000;
			3: return $signed(32'($urandom_range(0, 8000))) - 4000;
			4: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
			default: return $signed(32'($urandom_range(0, 32767))) - 16384;
		endcase
	endfunction

	task automatic test_directed();
		logic signed [31:0] corner[8];
		corner = '{32'sh8000_0000, 32'sh7fff_ffff, -32768, 32767, -32769, 32768, 0, -1};
		for (int i = 0; i < 8; i++)
			send_request(corner[i], corner[(i * 3 + 1) % 8]);
		send_request(20000, 20000);
		send_request(-30000, 5);
		send_request(5, -30000);
		send_request(0, 0);
	endtask

	task automatic test_zero_limit();
		write_register(REG_VOLTAGE_LIMIT, 16'd0);
		send_request(32'sh8000_0000, 32'sh7fff_ffff);
		send_request(100, -100);
		send_request(0, 0);
		drain_results();
	endtask

	task automatic test_random_settings();
		logic [15:0] lims[6];
		lims = '{16'd32767, 16'd1, 16'd16384, 16'd23170, 16'd5000, 16'd32000};
		for (int s = 0; s < 6; s++) begin
			write_register(REG_VOLTAGE_LIMIT, lims[s]);
			write_register(REG_FLUX_PRIORITY, 16'(s % 2));
			for (int i = 0; i < 305; i++)
				send_request(pick_command(), pick_command());
			drain_results();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		errors = 0;
		burst_left = 0;
		stall_mode = 1'b0;
		lim_setting = LIMIT_RESET;
		prio_setting = 1'b0;
		cmd.valid = 1'b0;
		cmd.d_command = '0;
		cmd.q_command = '0;
		res.ready = 1'b1;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		drain_results();
		write_register(REG_FLUX_PRIORITY, 16'd1);
		test_directed();
		drain_results();
		test_zero_limit();
		test_random_settings();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
